[rtl/pps_pkg.sv]
// pps_pkg: shared types and codes for the preemptive priority scheduler
// holds the sequencer state type, the ready queue entry layout and the op codes
// no dependencies
package pps_pkg;

  localparam logic OP_ARRIVE   = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_SCAN,
    S_FETCH,
    S_TAKE,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [31:0] arrival;
    logic [15:0] total;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } entry_t;

endpackage

[rtl/preemptive_priority_scheduler.sv]
// preemptive_priority_scheduler: running process register plus a ready queue memory,
// one item at a time; depends on pps_pkg
// sequencing: an arrival passes through S_ARRIVE and S_DONE before out_valid rises; a completion
// goes straight to S_DONE on an empty queue, else through S_SCAN, S_FETCH, S_TAKE and S_SHIFT
// throughput: one item in flight; in_ready is high only while the sequencer is idle
// reset: synchronous, clears the queue count, the running process and the output valid
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [15:0] proc_id,
  input  logic [31:0] arrival_time,
  input  logic [15:0] burst_time,
  input  logic [7:0]  priority_req,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] run_pid,
  output logic [31:0] run_arrival,
  output logic [15:0] run_total,
  output logic [15:0] run_remaining,
  output logic [7:0]  run_priority,
  output logic [31:0] run_start,
  output logic [31:0] run_end,
  output logic [4:0]  ready_count,
  output logic        dropped
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [AW-1:0] lag_idx;
  logic          lag_valid;
  logic [AW-1:0] best_idx;
  logic [7:0]    best_prio;
  logic          drop_r;

  logic [15:0] pid_r;
  logic [31:0] arr_r;
  logic [15:0] burst_r;
  logic [7:0]  prio_r;
  logic [31:0] now_r;

  logic [15:0] cur_pid;
  logic [31:0] cur_arrival;
  logic [15:0] cur_total;
  logic [15:0] cur_remaining;
  logic [7:0]  cur_prio;
  logic [31:0] cur_start;
  logic [31:0] cur_end;

  entry_t        mem [QUEUE_DEPTH];
  entry_t        rdata;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;

  logic          issue;
  logic          full;
  logic          slot_free;
  logic [31:0]   ran;
  logic [15:0]   rem_pre;

  assign issue     = idx < count;
  assign full      = count >= CW'(QUEUE_DEPTH);
  assign slot_free = !out_valid || out_ready;
  assign ran       = (now_r >= cur_start) ? (now_r - cur_start) : 32'd0;
  assign rem_pre   = (ran >= {16'd0, cur_remaining}) ? 16'd0 : (cur_remaining - ran[15:0]);

  // queue memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    raddr      = idx[AW-1:0];
    we         = 1'b0;
    waddr      = count[AW-1:0];
    wdata      = rdata;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (op == OP_ARRIVE) begin
            state_next = S_ARRIVE;
          end else if (count == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_ARRIVE: begin
        if (pid_r != 16'd0 && cur_pid != 16'd0 && !full) begin
          we = 1'b1;
          if (prio_r < cur_prio) begin
            wdata = '{pid: cur_pid, arrival: cur_arrival, total: cur_total,
                      remaining: rem_pre, prio: cur_prio};
          end else begin
            wdata = '{pid: pid_r, arrival: arr_r, total: burst_r,
                      remaining: burst_r, prio: prio_r};
          end
        end
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (!issue && !lag_valid) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        raddr      = best_idx;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (lag_valid) begin
          we    = 1'b1;
          waddr = lag_idx - AW'(1);
        end
        if (!issue && !lag_valid) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      lag_valid     <= 1'b0;
      out_valid     <= 1'b0;
      cur_pid       <= '0;
      cur_arrival   <= '0;
      cur_total     <= '0;
      cur_remaining <= '0;
      cur_prio      <= '0;
      cur_start     <= '0;
      cur_end       <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            lag_valid <= 1'b0;
            if (op == OP_COMPLETE && count == '0) begin
              cur_pid       <= '0;
              cur_arrival   <= '0;
              cur_total     <= '0;
              cur_remaining <= '0;
              cur_prio      <= '0;
              cur_start     <= '0;
              cur_end       <= '0;
            end
          end
        end
        S_ARRIVE: begin
          if (pid_r != 16'd0) begin
            if (cur_pid == 16'd0 || (!full && prio_r < cur_prio)) begin
              cur_pid       <= pid_r;
              cur_arrival   <= arr_r;
              cur_total     <= burst_r;
              cur_remaining <= burst_r;
              cur_prio      <= prio_r;
              cur_start     <= now_r;
              cur_end       <= now_r + 32'(burst_r);
            end
            if (cur_pid != 16'd0 && !full) begin
              count <= count + CW'(1);
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            lag_valid <= 1'b1;
          end else begin
            lag_valid <= 1'b0;
          end
        end
        S_TAKE: begin
          cur_pid       <= rdata.pid;
          cur_arrival   <= rdata.arrival;
          cur_total     <= rdata.total;
          cur_remaining <= rdata.remaining;
          cur_prio      <= rdata.prio;
          cur_start     <= now_r;
          cur_end       <= now_r + 32'(rdata.remaining);
          lag_valid     <= 1'b0;
        end
        S_SHIFT: begin
          if (issue) begin
            lag_valid <= 1'b1;
          end else begin
            lag_valid <= 1'b0;
            if (!lag_valid) begin
              count <= count - CW'(1);
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
          end
        end
        default: begin
          lag_valid <= 1'b0;
        end
      endcase
    end
  end

  // payload and sequencing registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          pid_r   <= proc_id;
          arr_r   <= arrival_time;
          burst_r <= burst_time;
          prio_r  <= priority_req;
          now_r   <= now;
          drop_r  <= 1'b0;
          idx     <= '0;
        end
      end
      S_ARRIVE: begin
        if (pid_r != 16'd0 && cur_pid != 16'd0 && full) begin
          drop_r <= 1'b1;
        end
      end
      S_SCAN: begin
        if (lag_valid && (lag_idx == '0 || rdata.prio < best_prio)) begin
          best_idx  <= lag_idx;
          best_prio <= rdata.prio;
        end
        if (issue) begin
          lag_idx <= idx[AW-1:0];
          idx     <= idx + CW'(1);
        end
      end
      S_TAKE: begin
        idx <= CW'(best_idx) + CW'(1);
      end
      S_SHIFT: begin
        if (issue) begin
          lag_idx <= idx[AW-1:0];
          idx     <= idx + CW'(1);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          run_pid       <= cur_pid;
          run_arrival   <= cur_arrival;
          run_total     <= cur_total;
          run_remaining <= cur_remaining;
          run_priority  <= cur_prio;
          run_start     <= cur_start;
          run_end       <= cur_end;
          ready_count   <= 5'(count);
          dropped       <= drop_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
